>>> hw/rtl/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg
// Shared types, constants and helpers for the streaming 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
package gb5_pkg;

  localparam int DEF_KERNEL_SIZE = 5;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT      = 1024;

  localparam int PIX_W    = 8;
  localparam int SIZE_W   = 11;
  localparam int ROW_W    = 10;
  localparam int COEF_W   = 17;
  localparam int NUM_GRP  = 6;
  localparam int GSUM_W   = 11;
  localparam int PROD_W   = GSUM_W + COEF_W;
  localparam int ACC_W    = 30;
  localparam int FRAC_W   = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_COEF_CENTER   = 3'd2;
  localparam logic [2:0] REG_COEF_EDGE_ONE = 3'd3;
  localparam logic [2:0] REG_COEF_EDGE_TWO = 3'd4;
  localparam logic [2:0] REG_COEF_DIAG_ONE = 3'd5;
  localparam logic [2:0] REG_COEF_KNIGHT   = 3'd6;
  localparam logic [2:0] REG_COEF_DIAG_TWO = 3'd7;

  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 11'd512;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 11'd512;
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = 17'd65536;

  // coefficient groups by (min, max) of the absolute offsets
  localparam logic [2:0] GRP_CENTER   = 3'd0;
  localparam logic [2:0] GRP_EDGE_ONE = 3'd1;
  localparam logic [2:0] GRP_EDGE_TWO = 3'd2;
  localparam logic [2:0] GRP_DIAG_ONE = 3'd3;
  localparam logic [2:0] GRP_KNIGHT   = 3'd4;
  localparam logic [2:0] GRP_DIAG_TWO = 3'd5;
  localparam logic [2:0] GRP_NONE     = 3'd6;

  typedef struct packed {
    logic [SIZE_W-1:0]              image_width;
    logic [SIZE_W-1:0]              image_height;
    logic [NUM_GRP-1:0][COEF_W-1:0] coef;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } win_ctl_t;

  function automatic logic [2:0] coef_group(input int i, input int j, input int half);
    int dr;
    int dc;
    int a;
    int b;
    logic [2:0] grp;
    dr = (i > half) ? i - half : half - i;
    dc = (j > half) ? j - half : half - j;
    a  = (dr < dc) ? dr : dc;
    b  = (dr < dc) ? dc : dr;
    grp = GRP_NONE;
    if (a == 0 && b == 0) grp = GRP_CENTER;
    if (a == 0 && b == 1) grp = GRP_EDGE_ONE;
    if (a == 0 && b == 2) grp = GRP_EDGE_TWO;
    if (a == 1 && b == 1) grp = GRP_DIAG_ONE;
    if (a == 1 && b == 2) grp = GRP_KNIGHT;
    if (a == 2 && b == 2) grp = GRP_DIAG_TWO;
    return grp;
  endfunction

endpackage

>>> hw/rtl/gb5_cfg_regs.sv
// ----------------------------------------------------------------------------
// gb5_cfg_regs
// APB-style register file: image size and the six kernel weights.
// ----------------------------------------------------------------------------
module gb5_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gb5_pkg::PADDR_W-1:0]  paddr,
  input  logic [gb5_pkg::PDATA_W-1:0]  pwdata,
  output logic [gb5_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output gb5_pkg::cfg_t                cfg
);

  gb5_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[gb5_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= gb5_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height <= gb5_pkg::RST_IMAGE_HEIGHT;
      // centre weight is group 0, the lowest slice
      cfg_r.coef         <= {{(gb5_pkg::NUM_GRP-1){gb5_pkg::COEF_W'(0)}},
                             gb5_pkg::RST_COEF_CENTER};
    end else if (wr_en) begin
      unique case (idx)
        gb5_pkg::REG_IMAGE_WIDTH:   cfg_r.image_width  <= pwdata[gb5_pkg::SIZE_W-1:0];
        gb5_pkg::REG_IMAGE_HEIGHT:  cfg_r.image_height <= pwdata[gb5_pkg::SIZE_W-1:0];
        gb5_pkg::REG_COEF_CENTER:   cfg_r.coef[gb5_pkg::GRP_CENTER]   <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        gb5_pkg::REG_COEF_EDGE_ONE: cfg_r.coef[gb5_pkg::GRP_EDGE_ONE] <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        gb5_pkg::REG_COEF_EDGE_TWO: cfg_r.coef[gb5_pkg::GRP_EDGE_TWO] <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        gb5_pkg::REG_COEF_DIAG_ONE: cfg_r.coef[gb5_pkg::GRP_DIAG_ONE] <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        gb5_pkg::REG_COEF_KNIGHT:   cfg_r.coef[gb5_pkg::GRP_KNIGHT]   <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        gb5_pkg::REG_COEF_DIAG_TWO: cfg_r.coef[gb5_pkg::GRP_DIAG_TWO] <=
                                      pwdata[gb5_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gb5_pkg::REG_IMAGE_WIDTH:   prdata = gb5_pkg::PDATA_W'(cfg_r.image_width);
      gb5_pkg::REG_IMAGE_HEIGHT:  prdata = gb5_pkg::PDATA_W'(cfg_r.image_height);
      gb5_pkg::REG_COEF_CENTER:   prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_CENTER]);
      gb5_pkg::REG_COEF_EDGE_ONE: prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_EDGE_ONE]);
      gb5_pkg::REG_COEF_EDGE_TWO: prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_EDGE_TWO]);
      gb5_pkg::REG_COEF_DIAG_ONE: prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_DIAG_ONE]);
      gb5_pkg::REG_COEF_KNIGHT:   prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_KNIGHT]);
      gb5_pkg::REG_COEF_DIAG_TWO: prdata = gb5_pkg::PDATA_W'(cfg_r.coef[gb5_pkg::GRP_DIAG_TWO]);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/gb5_line_buf.sv
// ----------------------------------------------------------------------------
// gb5_line_buf
// Raster position tracking, line store memory (read, roll, write back with
// forwarding) and the sliding pixel window.
// ----------------------------------------------------------------------------
module gb5_line_buf #(
  parameter int KERNEL_SIZE = gb5_pkg::DEF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = gb5_pkg::DEF_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gb5_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_pixel_in,
  input  logic                    in_frame_start,
  output logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] win,
  output gb5_pkg::win_ctl_t       win_ctl,
  input  logic                    win_take
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW   = CW + 1;
  localparam int CMPW = (EW > gb5_pkg::SIZE_W) ? EW : gb5_pkg::SIZE_W;
  localparam int SW   = gb5_pkg::SIZE_W;
  localparam int LW   = (KERNEL_SIZE - 1) * 8;

  localparam logic [CMPW-1:0] K_X     = CMPW'(KERNEL_SIZE);
  localparam logic [CMPW-1:0] MAXW_X  = CMPW'(MAX_WIDTH);
  localparam logic [SW-1:0]   K_H     = SW'(KERNEL_SIZE);
  localparam logic [SW-1:0]   MAXH_H  = SW'(gb5_pkg::MAX_HEIGHT);
  localparam logic [EW-1:0]   KM1_C   = EW'(KERNEL_SIZE - 1);
  localparam logic [SW-1:0]   KM1_R   = SW'(KERNEL_SIZE - 1);

  logic [LW-1:0] mem [MAX_WIDTH];

  logic [CW-1:0]  col_r, col_nxt;
  logic [gb5_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [CMPW-1:0] wx;
  logic [EW-1:0]   w_eff;
  logic [SW-1:0]   h_eff;
  logic [EW-1:0]   c0, c1;
  logic [SW-1:0]   r0, r1;
  logic            acc_emit, acc_last;
  logic            in_acc;

  logic            s1_v_r, s1_v_nxt;
  logic            s1_go;
  logic [CW-1:0]   s1_col_r;
  logic [7:0]      s1_pix_r;
  logic            s1_emit_r, s1_last_r;
  logic [LW-1:0]   rd_data_r;
  logic            fwd_hit_r;
  logic [LW-1:0]   fwd_data_r;
  logic [LW-1:0]   rows;
  logic [LW-1:0]   wr_data;

  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] win_r, win_nxt;
  logic            win_v_r, win_v_nxt;
  logic            win_last_r;

  // effective sizes
  always_comb begin
    wx = CMPW'(cfg.image_width);
    if (wx < K_X) begin
      w_eff = EW'(K_X);
    end else if (wx > MAXW_X) begin
      w_eff = EW'(MAXW_X);
    end else begin
      w_eff = EW'(wx);
    end
    if (cfg.image_height < K_H) begin
      h_eff = K_H;
    end else if (cfg.image_height > MAXH_H) begin
      h_eff = MAXH_H;
    end else begin
      h_eff = cfg.image_height;
    end
  end

  // position of the incoming word and the one after it
  always_comb begin
    c0 = in_frame_start ? '0 : EW'(col_r);
    r0 = in_frame_start ? '0 : SW'(row_r);
    if (c0 >= w_eff) c0 = '0;
    if (r0 >= h_eff) r0 = '0;
    acc_emit = (c0 >= KM1_C) && (r0 >= KM1_R);
    acc_last = (c0 == w_eff - EW'(1)) && (r0 == h_eff - SW'(1));
    c1 = c0 + EW'(1);
    r1 = r0 + SW'(1);
    if (c1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r1 >= h_eff) ? '0 : r1[gb5_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c1[CW-1:0];
      row_nxt = r0[gb5_pkg::ROW_W-1:0];
    end
  end

  assign s1_go    = s1_v_r && (!win_v_r || win_take);
  assign in_stall = s1_v_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign s1_v_nxt = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (in_acc) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        fwd_hit_r <= s1_go && (s1_col_r == c0[CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= c0[CW-1:0];
      s1_pix_r   <= in_pixel_in;
      s1_emit_r  <= acc_emit;
      s1_last_r  <= acc_last;
      fwd_data_r <= wr_data;
    end
  end

  // line store: one word per column, row i in byte i
  always_ff @(posedge clk) begin
    if (s1_go) mem[s1_col_r] <= wr_data;
    if (in_acc) rd_data_r <= mem[c0[CW-1:0]];
  end

  assign rows    = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign wr_data = {s1_pix_r, rows[LW-1:8]};

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
      win_nxt[i][KERNEL_SIZE-1] = (i < KERNEL_SIZE - 1) ? rows[i*8 +: 8] : s1_pix_r;
    end
  end

  always_comb begin
    if (s1_go) begin
      win_v_nxt = s1_emit_r;
    end else if (win_take) begin
      win_v_nxt = 1'b0;
    end else begin
      win_v_nxt = win_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      win_v_r <= 1'b0;
    end else begin
      win_v_r <= win_v_nxt;
      if (s1_go) win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) win_last_r <= s1_last_r;
  end

  assign win           = win_r;
  assign win_ctl.valid = win_v_r;
  assign win_ctl.last  = win_last_r;

endmodule

>>> hw/rtl/gb5_mac.sv
// ----------------------------------------------------------------------------
// gb5_mac
// Weighted sum of the window: group sums, six multiplies, two-step add,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module gb5_mac #(
  parameter int KERNEL_SIZE = gb5_pkg::DEF_KERNEL_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gb5_pkg::cfg_t           cfg,
  input  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] win,
  input  gb5_pkg::win_ctl_t       win_ctl,
  output logic                    win_take,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_pixel_out,
  output logic                    out_frame_last
);

  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int NG    = gb5_pkg::NUM_GRP;
  localparam int GW    = gb5_pkg::GSUM_W;
  localparam int PW    = gb5_pkg::PROD_W;
  localparam int AW    = gb5_pkg::ACC_W;
  localparam int FW    = gb5_pkg::FRAC_W;
  localparam logic [AW-1:0] HALF_LSB = AW'(1) << (FW - 1);

  logic [NG-1:0][GW-1:0] gsum;
  logic [NG-1:0][GW-1:0] gsum_r;
  logic [NG-1:0][PW-1:0] prod_r;
  logic [AW-1:0]         ps0_r, ps1_r;
  logic [AW-1:0]         acc;

  logic a_v_r, b_v_r, c_v_r, o_v_r;
  logic a_last_r, b_last_r, c_last_r, o_last_r;
  logic [7:0] o_pix_r;
  logic a_take, b_take, c_take, o_take;

  always_comb begin
    logic [2:0] grp;
    gsum = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        grp = gb5_pkg::coef_group(i, j, HALF);
        if (grp != gb5_pkg::GRP_NONE) gsum[grp] = gsum[grp] + GW'(win[i][j]);
      end
    end
  end

  assign o_take = !o_v_r || !out_stall;
  assign c_take = !c_v_r || o_take;
  assign b_take = !b_v_r || c_take;
  assign a_take = !a_v_r || b_take;
  assign win_take = a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_take) a_v_r <= win_ctl.valid;
      if (b_take) b_v_r <= a_v_r;
      if (c_take) c_v_r <= b_v_r;
      if (o_take) o_v_r <= c_v_r;
    end
  end

  assign acc = ps0_r + ps1_r + HALF_LSB;

  always_ff @(posedge clk) begin
    if (a_take && win_ctl.valid) begin
      gsum_r   <= gsum;
      a_last_r <= win_ctl.last;
    end
    if (b_take && a_v_r) begin
      for (int g = 0; g < NG; g++) begin
        prod_r[g] <= PW'(gsum_r[g]) * PW'(cfg.coef[g]);
      end
      b_last_r <= a_last_r;
    end
    if (c_take && b_v_r) begin
      ps0_r    <= AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2]);
      ps1_r    <= AW'(prod_r[3]) + AW'(prod_r[4]) + AW'(prod_r[5]);
      c_last_r <= b_last_r;
    end
    if (o_take && c_v_r) begin
      o_pix_r  <= (|acc[AW-1:FW+8]) ? 8'hFF : acc[FW+7:FW];
      o_last_r <= c_last_r;
    end
  end

  assign out_valid      = o_v_r;
  assign out_pixel_out  = o_pix_r;
  assign out_frame_last = o_last_r;

endmodule

>>> hw/rtl/gaussian_blur_5x5_stream.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_stream
// Streaming 5x5 Gaussian blur on 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel (in_*): one pixel word per accepted cycle, in_frame_start on
// the first pixel of a frame. Output channel (out_*): one filtered word per
// interior centre, out_frame_last on the frame's last one; border positions
// give no word. Both channels use valid/stall; a word moves when valid is high
// and stall is low.
// Throughput is one pixel per clock while the output is not stalled: the line
// store is read and written back once per pixel at its column, and a write
// followed at once by a read of the same column is forwarded.
// After the pixel completing its window is accepted, its result is registered
// through store read, window shift, group sums, multiply and two adds.
// A stalled receiver holds the output register; empty stages still drain, so
// input is taken until the pipeline is full back to the line store.
// Reset clears positions, window, pipeline valids and registers to their
// defaults; the line store is not cleared. The APB port (pready always high)
// should only be written while the block is idle.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_stream #(
  parameter int KERNEL_SIZE = gb5_pkg::DEF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = gb5_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gb5_pkg::PADDR_W-1:0]  paddr,
  input  logic [gb5_pkg::PDATA_W-1:0]  pwdata,
  output logic [gb5_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_pixel_in,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_pixel_out,
  output logic                         out_frame_last
);

  gb5_pkg::cfg_t     cfg;
  gb5_pkg::win_ctl_t win_ctl;
  logic              win_take;
  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] win;

  gb5_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gb5_line_buf #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_line_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .win            (win),
    .win_ctl        (win_ctl),
    .win_take       (win_take)
  );

  gb5_mac #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .win            (win),
    .win_ctl        (win_ctl),
    .win_take       (win_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

endmodule

>>> hw/rtl/gb5_checker.sv
// ----------------------------------------------------------------------------
// gb5_checker
// Port-level checks on the blur's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module gb5_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_out,
  input logic       out_frame_last
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
                               $stable(out_frame_last))
    else $error("output word changed under stall");

  // input can only back up behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a pixel offered while the output is free is taken
  a_free_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("pixel refused with free output");

endmodule

bind gaussian_blur_5x5_stream gb5_checker u_gb5_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_out  (out_pixel_out),
  .out_frame_last (out_frame_last)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_blur_5x5_stream. Random pixel frames go in
// through a queue-fed driver; a predictor keeps its own line stores, window
// and positions and queues the filtered word any accepted pixel should give.
// The monitor compares every word leaving the block with the oldest one due.
// Sizes and kernels change between phases only, with the block drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int KSZ          = gb5_pkg::DEF_KERNEL_SIZE;
  localparam int MAXW         = gb5_pkg::DEF_MAX_WIDTH;
  localparam int HALF         = KSZ / 2;
  localparam int NUM_REGS     = gb5_pkg::REG_COEF_DIAG_TWO + 1;
  localparam int RANDOM_WORDS = 900;
  localparam int PHASE_WORDS  = 300;
  localparam int WIDE_ROW     = 96;
  localparam int TALL_ROWS    = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam logic [31:0] SIZE_MASK = (32'd1 << gb5_pkg::SIZE_W) - 1;
  localparam logic [31:0] COEF_MASK = (32'd1 << gb5_pkg::COEF_W) - 1;
  localparam logic [31:0] COEF_ONE  = 32'd1 << gb5_pkg::FRAC_W;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } blur_result_t;

  typedef enum {PACE_FREE, PACE_SLOW_SOURCE, PACE_SLOW_SINK, PACE_BOTH} pace_t;
  typedef enum {KERN_SMOOTH, KERN_SINGLE, KERN_RAW} kernel_kind_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [gb5_pkg::PADDR_W-1:0]   paddr = '0;
  logic [gb5_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [gb5_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_pixel_in = '0;
  logic                          in_frame_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_pixel_out;
  logic                          out_frame_last;

  pixel_word_t  raw_q[$];
  blur_result_t blurred_q[$];

  logic [31:0]  cfg_shadow [NUM_REGS];
  bit   [7:0]   line_mem [KSZ-1][MAXW];
  bit   [7:0]   win [KSZ][KSZ];
  int unsigned  col_pos = 0;
  int unsigned  row_pos = 0;

  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  cycles = 0;

  gaussian_blur_5x5_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [31:0] v, input int unsigned hi);
    if (v < KSZ) return KSZ;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the shadow of the block by one pixel and queue the word it yields.
  function automatic void blur_pixel(input pixel_word_t w);
    int unsigned  fw, fh, c, r;
    int           i, j, dr, dc, mn, mx;
    logic [2:0]   grp;
    logic [63:0]  acc;
    blur_result_t res;
    fw = clamp_dim(cfg_shadow[gb5_pkg::REG_IMAGE_WIDTH], MAXW);
    fh = clamp_dim(cfg_shadow[gb5_pkg::REG_IMAGE_HEIGHT], gb5_pkg::MAX_HEIGHT);
    if (w.start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= fw) col_pos = 0;
    if (row_pos >= fh) row_pos = 0;
    c = col_pos;
    r = row_pos;
    for (i = 0; i < KSZ; i++) begin
      for (j = 0; j < KSZ - 1; j++) win[i][j] = win[i][j+1];
      win[i][KSZ-1] = (i < KSZ - 1) ? line_mem[i][c] : w.pixel;
    end
    for (i = 0; i < KSZ - 2; i++) line_mem[i][c] = line_mem[i+1][c];
    line_mem[KSZ-2][c] = w.pixel;
    if (r >= KSZ - 1 && c >= KSZ - 1) begin
      acc = '0;
      for (i = 0; i < KSZ; i++) begin
        for (j = 0; j < KSZ; j++) begin
          dr = (i > HALF) ? i - HALF : HALF - i;
          dc = (j > HALF) ? j - HALF : HALF - j;
          mn = (dr < dc) ? dr : dc;
          mx = (dr < dc) ? dc : dr;
          grp = gb5_pkg::GRP_NONE;
          if (mn == 0 && mx == 0) grp = gb5_pkg::GRP_CENTER;
          if (mn == 0 && mx == 1) grp = gb5_pkg::GRP_EDGE_ONE;
          if (mn == 0 && mx == 2) grp = gb5_pkg::GRP_EDGE_TWO;
          if (mn == 1 && mx == 1) grp = gb5_pkg::GRP_DIAG_ONE;
          if (mn == 1 && mx == 2) grp = gb5_pkg::GRP_KNIGHT;
          if (mn == 2 && mx == 2) grp = gb5_pkg::GRP_DIAG_TWO;
          if (grp != gb5_pkg::GRP_NONE)
            acc += 64'(win[i][j]) * 64'(cfg_shadow[gb5_pkg::REG_COEF_CENTER + grp]);
        end
      end
      acc = (acc + (64'd1 << (gb5_pkg::FRAC_W - 1))) >> gb5_pkg::FRAC_W;
      res.value = (acc > 64'd255) ? 8'hFF : acc[7:0];
      res.last  = (r == fh - 1 && c == fw - 1);
      blurred_q.push_back(res);
    end
    c++;
    if (c >= fw) begin
      c = 0;
      r++;
      if (r >= fh) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  // Driver: presents the head of raw_q, holds it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blur_pixel(raw_q.pop_front());
        words_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (raw_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
          in_valid       <= 1'b1;
          in_pixel_in    <= raw_q[0].pixel;
          in_frame_start <= raw_q[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    blur_result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          flag_mismatch("filtered word with nothing due", -1, out_pixel_out);
        end else begin
          due = blurred_q.pop_front();
          words_checked++;
          if (out_pixel_out !== due.value)
            flag_mismatch("out_pixel_out", due.value, out_pixel_out);
          if (out_frame_last !== due.last)
            flag_mismatch("out_frame_last", due.last, out_frame_last);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d words still due", cycles, blurred_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == gb5_pkg::REG_IMAGE_WIDTH || idx == gb5_pkg::REG_IMAGE_HEIGHT) ?
           SIZE_MASK : COEF_MASK;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // unused upper bits sometimes carry junk
    pwdata  <= (value & mask) | (($urandom_range(3) == 0) ? ($urandom() & ~mask) : 32'h0);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_shadow[idx] = value & mask;
  endtask

  task automatic load_kernel(input kernel_kind_t kind);
    int unsigned raw [gb5_pkg::NUM_GRP];
    int unsigned total, g, hot;
    total = 0;
    hot = $urandom_range(gb5_pkg::NUM_GRP - 1);
    for (g = 0; g < gb5_pkg::NUM_GRP; g++) begin
      raw[g] = $urandom_range(255);
      total += raw[g] * ((g == gb5_pkg::GRP_CENTER) ? 1 :
                         (g == gb5_pkg::GRP_KNIGHT) ? 8 : 4);
    end
    if (total == 0) begin
      raw[gb5_pkg::GRP_CENTER] = 1;
      total = 1;
    end
    for (g = 0; g < gb5_pkg::NUM_GRP; g++) begin
      case (kind)
        KERN_SMOOTH: write_reg(gb5_pkg::REG_COEF_CENTER + 3'(g), raw[g] * COEF_ONE / total);
        KERN_SINGLE: write_reg(gb5_pkg::REG_COEF_CENTER + 3'(g),
                               (g == hot) ? ($urandom_range(1) ? COEF_ONE : COEF_MASK) : 0);
        default:     write_reg(gb5_pkg::REG_COEF_CENTER + 3'(g), $urandom() & COEF_MASK);
      endcase
    end
  endtask

  task automatic push_words(input int unsigned count, input bit with_start);
    pixel_word_t w;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      w.pixel = $urandom_range(255);
      w.start = with_start && k == 0;
      raw_q.push_back(w);
    end
  endtask

  task automatic set_pace(input pace_t pace);
    gap_pct   = (pace == PACE_SLOW_SOURCE) ? 75 : (pace == PACE_BOTH) ? 24 : 0;
    stall_pct = (pace == PACE_SLOW_SINK)   ? 75 : (pace == PACE_BOTH) ? 24 : 0;
  endtask

  // All words in and out, then time for pixels still in the pipe.
  task automatic drain();
    while (raw_q.size() != 0 || blurred_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    pixel_word_t w;
    int unsigned phase, random_words, n, fw, fh, len, k, wv, hv, pick;
    bit          opening;
    for (k = 0; k < NUM_REGS; k++) cfg_shadow[k] = '0;
    cfg_shadow[gb5_pkg::REG_IMAGE_WIDTH]  = gb5_pkg::RST_IMAGE_WIDTH;
    cfg_shadow[gb5_pkg::REG_IMAGE_HEIGHT] = gb5_pkg::RST_IMAGE_HEIGHT;
    cfg_shadow[gb5_pkg::REG_COEF_CENTER]  = gb5_pkg::RST_COEF_CENTER;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 512-pixel rows, nothing due before the fifth row
    set_pace(PACE_FREE);
    push_words(gb5_pkg::RST_IMAGE_WIDTH / 8, 1'b1);
    drain();

    // reset kernel passes the centre through
    write_reg(gb5_pkg::REG_IMAGE_WIDTH, KSZ + 3);
    write_reg(gb5_pkg::REG_IMAGE_HEIGHT, KSZ + 1);
    push_words((KSZ + 3) * (KSZ + 1), 1'b1);
    drain();

    // smallest frame, coefficients at their extremes, pixels 0 and 255
    write_reg(gb5_pkg::REG_IMAGE_WIDTH, KSZ);
    write_reg(gb5_pkg::REG_IMAGE_HEIGHT, KSZ);
    write_reg(gb5_pkg::REG_COEF_CENTER, 0);
    write_reg(gb5_pkg::REG_COEF_EDGE_ONE, COEF_ONE);
    write_reg(gb5_pkg::REG_COEF_EDGE_TWO, COEF_MASK);
    write_reg(gb5_pkg::REG_COEF_DIAG_ONE, 1);
    write_reg(gb5_pkg::REG_COEF_KNIGHT, 0);
    write_reg(gb5_pkg::REG_COEF_DIAG_TWO, COEF_ONE - 1);
    set_pace(PACE_SLOW_SOURCE);
    for (k = 0; k < KSZ * KSZ; k++) begin
      w.pixel = (k % 3 == 0) ? 8'hFF : 8'h00;
      w.start = (k == 0);
      raw_q.push_back(w);
    end
    drain();

    // wide row, shortest frame
    write_reg(gb5_pkg::REG_IMAGE_WIDTH, WIDE_ROW);
    write_reg(gb5_pkg::REG_IMAGE_HEIGHT, KSZ);
    load_kernel(KERN_SMOOTH);
    set_pace(PACE_SLOW_SINK);
    push_words(WIDE_ROW * KSZ, 1'b1);
    drain();

    // sizes past both ends clamp: narrowest row, tallest frame
    write_reg(gb5_pkg::REG_IMAGE_WIDTH, KSZ - 2);
    write_reg(gb5_pkg::REG_IMAGE_HEIGHT, SIZE_MASK);
    load_kernel(KERN_SMOOTH);
    set_pace(PACE_BOTH);
    push_words(KSZ * TALL_ROWS, 1'b1);
    phase = 4;

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      phase++;
      drain();
      wv = ($urandom_range(5) == 0) ? $urandom_range(KSZ - 1) : $urandom_range(KSZ, 12);
      hv = ($urandom_range(5) == 0) ? $urandom_range(KSZ - 1) : $urandom_range(KSZ, 10);
      write_reg(gb5_pkg::REG_IMAGE_WIDTH, wv);
      write_reg(gb5_pkg::REG_IMAGE_HEIGHT, hv);
      load_kernel(kernel_kind_t'($urandom_range(KERN_RAW)));
      set_pace(pace_t'(phase % 4));
      fw = clamp_dim(wv, MAXW);
      fh = clamp_dim(hv, gb5_pkg::MAX_HEIGHT);
      n = 0;
      opening = 1'b1;
      while (n < PHASE_WORDS) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          len = $urandom_range(1, fw * fh - 1);    // cut short, next frame restarts
          push_words(len, 1'b1);
        end else if (pick == 1 && !opening) begin
          len = fw * fh;                           // no start flag, position wraps
          push_words(len, 1'b0);
        end else begin
          len = fw * fh;
          push_words(len, 1'b1);
        end
        n += len;
        opening = 1'b0;
      end
      random_words += n;
    end
    drain();

    $display("Sent %0d pixel words over %0d register settings, checked %0d filtered words",
             words_sent, phase + 1, words_checked);
    $display("Covered clamped sizes, saturating kernels, unflagged and cut-short frames");
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gb5_pkg.sv
hw/rtl/gb5_cfg_regs.sv
hw/rtl/gb5_line_buf.sv
hw/rtl/gb5_mac.sv
hw/rtl/gaussian_blur_5x5_stream.sv
hw/rtl/gb5_checker.sv
test/tb.sv
